// ===== rtl/core/tosp_pkg.sv =====
package tosp_pkg;

  // grid index width of both angle fields
  localparam int IDX_W = 6;

  // configuration port address width: six 32-bit registers at 4*i
  localparam int ADDR_W = 5;

  // register stages per unit
  localparam int DIR_STAGES   = 2;
  localparam int FORM_STAGES  = 4;
  localparam int POINT_STAGES = 2;
  localparam int STAGES       = DIR_STAGES + FORM_STAGES + POINT_STAGES;

  localparam logic signed [65:0] MAX32 = 66'sd2147483647;
  localparam logic signed [65:0] MIN32 = -66'sd2147483648;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec3_t;

  typedef struct packed {
    logic signed [31:0] xx;
    logic signed [31:0] yy;
    logic signed [31:0] zz;
    logic signed [31:0] xy;
    logic signed [31:0] xz;
    logic signed [31:0] yz;
  } tensor_t;

  // unit direction in q2.30 plus the center riding along
  typedef struct packed {
    vec3_t d;
    vec3_t center;
  } dir_t;

  // clipped radius, its flag, and what the point stage still needs
  typedef struct packed {
    logic signed [31:0] r;
    logic               sat;
    vec3_t              d;
    vec3_t              center;
  } rad_t;

  typedef struct packed {
    vec3_t p;
    logic  sat;
  } point_t;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] val;
  } clip_t;

  // round to nearest, ties away from zero, then arithmetic shift by s
  function automatic logic signed [65:0] round_shift(input logic signed [65:0] v,
                                                     input int unsigned s);
    logic signed [65:0] half;
    logic signed [65:0] adj;
    half = 66'sd1 <<< (s - 1);
    adj  = half - $signed({65'd0, v[65]});
    return (v + adj) >>> s;
  endfunction

  function automatic clip_t clip32(input logic signed [65:0] v);
    clip_t c;
    if (v > MAX32) begin
      c.sat = 1'b1;
      c.val = 32'sh7fff_ffff;
    end else if (v < MIN32) begin
      c.sat = 1'b1;
      c.val = 32'sh8000_0000;
    end else begin
      c.sat = 1'b0;
      c.val = v[31:0];
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/tosp_if.sv =====
interface tosp_in_if;
  logic                         valid;
  logic                         ready;
  logic [tosp_pkg::IDX_W-1:0]   polar_index;
  logic [tosp_pkg::IDX_W-1:0]   azimuth_index;
  logic signed [31:0]           center_x;
  logic signed [31:0]           center_y;
  logic signed [31:0]           center_z;

  modport source (
    output valid, polar_index, azimuth_index, center_x, center_y, center_z,
    input  ready
  );
  modport sink (
    input  valid, polar_index, azimuth_index, center_x, center_y, center_z,
    output ready
  );
endinterface

interface tosp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic               saturated;

  modport source (
    output valid, point_x, point_y, point_z, saturated,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_z, saturated,
    output ready
  );
endinterface

// ===== rtl/core/tensor_ovaloid_surface_point_core.sv =====
// surface point generator for a quadratic-form ovaloid: each input word names a grid
// point (polar index i, azimuth index j) and a q16.16 center, and yields one output word
// center + r*d, where d is the unit direction at phi = pi*i/GRID_POINTS and
// theta = 2*pi*j/GRID_POINTS and r = 0.03 * d'Td from the symmetric tensor in the six
// configuration registers. the pipeline has 8 register stages, and one word per cycle is
// sustained while the output side is ready.
// the stages are table lookup, direction, pair products, tensor weights, six-term sum,
// radius scaling and clip, radius times direction, and round, add and clip.
// every stage holds its word under a stall while emptier stages downstream keep filling,
// so input ready stays high as long as any stage has room. coordinates and the radius
// clip to the 32-bit range and set saturated. polar index counts modulo 2*GRID_POINTS and
// azimuth index modulo GRID_POINTS. tensor registers sit at byte address 4*i in the order
// xx, yy, zz, xy, xz, yz, reset to zero, and are meant to be written with the pipe empty.
module tensor_ovaloid_surface_point_core #(
  parameter int GRID_POINTS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  tosp_in_if.sink                     in_chan,
  tosp_out_if.source                  out_chan,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tosp_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int LAST   = tosp_pkg::STAGES - 1;
  localparam int FORM_0 = tosp_pkg::DIR_STAGES;
  localparam int PT_0   = tosp_pkg::DIR_STAGES + tosp_pkg::FORM_STAGES;

  tosp_pkg::tensor_t tensor;
  tosp_pkg::vec3_t   center;
  tosp_pkg::dir_t    dir_w;
  tosp_pkg::rad_t    rad_w;
  tosp_pkg::point_t  pt_w;

  // one valid bit per stage; a stage loads when it is empty or its successor loads
  logic [tosp_pkg::STAGES-1:0] valid_r;
  logic [tosp_pkg::STAGES-1:0] valid_nxt;
  logic [tosp_pkg::STAGES-1:0] stage_en;

  always_comb begin
    stage_en[LAST] = !valid_r[LAST] || out_chan.ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      stage_en[k] = !valid_r[k] || stage_en[k + 1];
    end
  end

  always_comb begin
    valid_nxt[0] = stage_en[0] ? in_chan.valid : valid_r[0];
    for (int k = 1; k <= LAST; k++) begin
      valid_nxt[k] = stage_en[k] ? valid_r[k - 1] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_chan.ready = stage_en[0];

  assign center.x = in_chan.center_x;
  assign center.y = in_chan.center_y;
  assign center.z = in_chan.center_z;

  tosp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .tensor  (tensor)
  );

  // trig tables and unit direction
  tosp_dir #(
    .GRID_POINTS (GRID_POINTS)
  ) u_dir (
    .clk           (clk),
    .stage_en      (stage_en[tosp_pkg::DIR_STAGES-1:0]),
    .polar_index   (in_chan.polar_index),
    .azimuth_index (in_chan.azimuth_index),
    .center        (center),
    .dir_out       (dir_w)
  );

  // quadratic form and radius
  tosp_form u_form (
    .clk      (clk),
    .stage_en (stage_en[PT_0-1:FORM_0]),
    .tensor   (tensor),
    .dir_in   (dir_w),
    .rad_out  (rad_w)
  );

  // radius times direction plus center; last stage is the output register
  tosp_point u_point (
    .clk      (clk),
    .stage_en (stage_en[LAST:PT_0]),
    .rad_in   (rad_w),
    .point    (pt_w)
  );

  assign out_chan.valid     = valid_r[LAST];
  assign out_chan.point_x   = pt_w.p.x;
  assign out_chan.point_y   = pt_w.p.y;
  assign out_chan.point_z   = pt_w.p.z;
  assign out_chan.saturated = pt_w.sat;

endmodule

// ===== rtl/core/tosp_cfg.sv =====
module tosp_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tosp_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output tosp_pkg::tensor_t           tensor
);

  localparam logic [2:0] REG_XX = 3'd0;
  localparam logic [2:0] REG_YY = 3'd1;
  localparam logic [2:0] REG_ZZ = 3'd2;
  localparam logic [2:0] REG_XY = 3'd3;
  localparam logic [2:0] REG_XZ = 3'd4;
  localparam logic [2:0] REG_YZ = 3'd5;

  tosp_pkg::tensor_t tensor_r;
  tosp_pkg::tensor_t tensor_nxt;
  logic [2:0]        reg_idx;
  logic              wr_en;

  assign reg_idx = paddr[tosp_pkg::ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign tensor  = tensor_r;

  always_comb begin
    tensor_nxt = tensor_r;
    if (wr_en) begin
      case (reg_idx)
        REG_XX:  tensor_nxt.xx = pwdata;
        REG_YY:  tensor_nxt.yy = pwdata;
        REG_ZZ:  tensor_nxt.zz = pwdata;
        REG_XY:  tensor_nxt.xy = pwdata;
        REG_XZ:  tensor_nxt.xz = pwdata;
        REG_YZ:  tensor_nxt.yz = pwdata;
        default: tensor_nxt = tensor_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_XX:  prdata = tensor_r.xx;
      REG_YY:  prdata = tensor_r.yy;
      REG_ZZ:  prdata = tensor_r.zz;
      REG_XY:  prdata = tensor_r.xy;
      REG_XZ:  prdata = tensor_r.xz;
      REG_YZ:  prdata = tensor_r.yz;
      default: prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tensor_r <= '0;
    end else begin
      tensor_r <= tensor_nxt;
    end
  end

endmodule

// ===== rtl/core/tosp_dir.sv =====
module tosp_dir #(
  parameter int GRID_POINTS = 64
) (
  input  logic                            clk,
  input  logic [tosp_pkg::DIR_STAGES-1:0] stage_en,
  input  logic [tosp_pkg::IDX_W-1:0]      polar_index,
  input  logic [tosp_pkg::IDX_W-1:0]      azimuth_index,
  input  tosp_pkg::vec3_t                 center,
  output tosp_pkg::dir_t                  dir_out
);

  localparam int TRIG_ENTRIES = 2 ** tosp_pkg::IDX_W;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned MASK30 = 64'h3fff_ffff;
  localparam longint unsigned MASK32 = 64'hffff_ffff;
  // d*(d+1) for d = 1..16; cosine takes the odd d, sine the even d
  localparam longint unsigned TAYLOR_DIV [16] = '{
    64'd2, 64'd6, 64'd12, 64'd20, 64'd30, 64'd42, 64'd56, 64'd72,
    64'd90, 64'd110, 64'd132, 64'd156, 64'd182, 64'd210, 64'd240, 64'd272
  };

  // each entry holds {sin, cos} in q1.15
  typedef logic [TRIG_ENTRIES-1:0][31:0] tab_t;

  function automatic longint taylor_q30(input longint unsigned t0,
                                        input longint unsigned x2,
                                        input int first_idx);
    longint          acc;
    longint unsigned term;
    acc  = longint'(t0);
    term = t0;
    for (int n = 0; n < 8; n++) begin
      term = (term * x2) >> 30;
      term = term / TAYLOR_DIV[first_idx + 2 * n];
      if ((n % 2) == 0) acc = acc - longint'(term);
      else              acc = acc + longint'(term);
    end
    return acc;
  endfunction

  function automatic logic signed [15:0] q30_to_q15(input longint v);
    longint r;
    r = (v < 0) ? 64'sd0 : v;
    r = (r + 64'sd16384) >>> 15;
    if (r > 64'sd32767) r = 64'sd32767;
    return r[15:0];
  endfunction

  // sine and cosine of a grid angle, polar grid spans half a turn
  function automatic logic [31:0] trig_pair(input int unsigned p, input bit polar);
    longint unsigned    a;
    longint unsigned    x;
    longint unsigned    x2;
    logic [1:0]         quad;
    logic signed [15:0] s;
    logic signed [15:0] c;
    logic [31:0]        res;
    if (polar) begin
      a = ((64'(p % (2 * GRID_POINTS)) << 32) + GRID_POINTS)
          / (2 * GRID_POINTS);
    end else begin
      a = ((64'(p % GRID_POINTS) << 32) + GRID_POINTS / 2)
          / GRID_POINTS;
    end
    a    = a & MASK32;
    quad = a[31:30];
    x    = ((a & MASK30) * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    s    = q30_to_q15(taylor_q30(x, x2, 1));
    c    = q30_to_q15(taylor_q30(64'd1 << 30, x2, 0));
    case (quad)
      2'd0:    res = {s, c};
      2'd1:    res = {c, -s};
      2'd2:    res = {-s, -c};
      default: res = {-c, s};
    endcase
    return res;
  endfunction

  function automatic tab_t build_tab(input bit polar);
    tab_t t;
    for (int p = 0; p < TRIG_ENTRIES; p++) begin
      t[p] = trig_pair(p, polar);
    end
    return t;
  endfunction

  localparam tab_t POL_TAB = build_tab(1'b1);
  localparam tab_t AZI_TAB = build_tab(1'b0);

  // stage 0: table lookup
  logic signed [15:0] sp_r, cp_r, st_r, ct_r;
  logic [31:0]        pol_nxt, azi_nxt;
  tosp_pkg::vec3_t    ctr_r;

  assign pol_nxt = POL_TAB[polar_index];
  assign azi_nxt = AZI_TAB[azimuth_index];

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      sp_r  <= pol_nxt[31:16];
      cp_r  <= pol_nxt[15:0];
      st_r  <= azi_nxt[31:16];
      ct_r  <= azi_nxt[15:0];
      ctr_r <= center;
    end
  end

  // stage 1: direction products
  tosp_pkg::dir_t     dir_r;
  tosp_pkg::dir_t     dir_nxt;
  logic signed [31:0] dx_nxt, dy_nxt;

  assign dx_nxt = sp_r * ct_r;
  assign dy_nxt = sp_r * st_r;

  always_comb begin
    dir_nxt.d.x    = dx_nxt;
    dir_nxt.d.y    = dy_nxt;
    dir_nxt.d.z    = {cp_r[15], cp_r, 15'd0};
    dir_nxt.center = ctr_r;
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      dir_r <= dir_nxt;
    end
  end

  assign dir_out = dir_r;

endmodule

// ===== rtl/core/tosp_form.sv =====
module tosp_form (
  input  logic                             clk,
  input  logic [tosp_pkg::FORM_STAGES-1:0] stage_en,
  input  tosp_pkg::tensor_t                tensor,
  input  tosp_pkg::dir_t                   dir_in,
  output tosp_pkg::rad_t                   rad_out
);

  localparam logic signed [27:0] RADIUS_SCALE_Q32 = 28'sd128849019;

  // stage 2: direction pair products rounded to q30
  logic signed [63:0] pxx, pyy, pzz, pxy, pxz, pyz;
  logic signed [31:0] qxx_r, qyy_r, qzz_r, qxy_r, qxz_r, qyz_r;
  tosp_pkg::dir_t     d2_r;

  assign pxx = dir_in.d.x * dir_in.d.x;
  assign pyy = dir_in.d.y * dir_in.d.y;
  assign pzz = dir_in.d.z * dir_in.d.z;
  assign pxy = dir_in.d.x * dir_in.d.y;
  assign pxz = dir_in.d.x * dir_in.d.z;
  assign pyz = dir_in.d.y * dir_in.d.z;

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      qxx_r <= 32'(tosp_pkg::round_shift(66'(pxx), 30));
      qyy_r <= 32'(tosp_pkg::round_shift(66'(pyy), 30));
      qzz_r <= 32'(tosp_pkg::round_shift(66'(pzz), 30));
      qxy_r <= 32'(tosp_pkg::round_shift(66'(pxy), 30));
      qxz_r <= 32'(tosp_pkg::round_shift(66'(pxz), 30));
      qyz_r <= 32'(tosp_pkg::round_shift(66'(pyz), 30));
      d2_r  <= dir_in;
    end
  end

  // stage 3: weight by tensor elements, off-diagonal terms count twice
  logic signed [64:0] mxx, myy, mzz, mxy, mxz, myz;
  logic signed [33:0] txx_r, tyy_r, tzz_r, txy_r, txz_r, tyz_r;
  tosp_pkg::dir_t     d3_r;

  assign mxx = qxx_r * tensor.xx;
  assign myy = qyy_r * tensor.yy;
  assign mzz = qzz_r * tensor.zz;
  assign mxy = qxy_r * tensor.xy * 65'sd2;
  assign mxz = qxz_r * tensor.xz * 65'sd2;
  assign myz = qyz_r * tensor.yz * 65'sd2;

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      txx_r <= 34'(tosp_pkg::round_shift(66'(mxx), 30));
      tyy_r <= 34'(tosp_pkg::round_shift(66'(myy), 30));
      tzz_r <= 34'(tosp_pkg::round_shift(66'(mzz), 30));
      txy_r <= 34'(tosp_pkg::round_shift(66'(mxy), 30));
      txz_r <= 34'(tosp_pkg::round_shift(66'(mxz), 30));
      tyz_r <= 34'(tosp_pkg::round_shift(66'(myz), 30));
      d3_r  <= d2_r;
    end
  end

  // stage 4: exact sum of the six terms
  logic signed [36:0] sum_nxt;
  logic signed [36:0] sum_r;
  tosp_pkg::dir_t     d4_r;

  assign sum_nxt = txx_r + tyy_r + tzz_r + txy_r + txz_r + tyz_r;

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      sum_r <= sum_nxt;
      d4_r  <= d3_r;
    end
  end

  // stage 5: radius scale, round from q48 and clip
  logic signed [64:0] scaled;
  tosp_pkg::clip_t    rad_clip;
  tosp_pkg::rad_t     rad_r;
  tosp_pkg::rad_t     rad_nxt;

  assign scaled   = sum_r * RADIUS_SCALE_Q32;
  assign rad_clip = tosp_pkg::clip32(tosp_pkg::round_shift(66'(scaled), 32));

  always_comb begin
    rad_nxt.r      = rad_clip.val;
    rad_nxt.sat    = rad_clip.sat;
    rad_nxt.d      = d4_r.d;
    rad_nxt.center = d4_r.center;
  end

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      rad_r <= rad_nxt;
    end
  end

  assign rad_out = rad_r;

endmodule

// ===== rtl/core/tosp_point.sv =====
module tosp_point (
  input  logic                              clk,
  input  logic [tosp_pkg::POINT_STAGES-1:0] stage_en,
  input  tosp_pkg::rad_t                    rad_in,
  output tosp_pkg::point_t                  point
);

  // stage 6: radius times direction
  logic signed [63:0] mx, my, mz;
  logic signed [63:0] mx_r, my_r, mz_r;
  tosp_pkg::vec3_t    ctr_r;
  logic               sat_r;

  assign mx = rad_in.r * rad_in.d.x;
  assign my = rad_in.r * rad_in.d.y;
  assign mz = rad_in.r * rad_in.d.z;

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      mx_r  <= mx;
      my_r  <= my;
      mz_r  <= mz;
      ctr_r <= rad_in.center;
      sat_r <= rad_in.sat;
    end
  end

  // stage 7: round from q46, add center, clip
  tosp_pkg::clip_t  cx, cy, cz;
  tosp_pkg::point_t pt_r;
  tosp_pkg::point_t pt_nxt;

  assign cx = tosp_pkg::clip32(tosp_pkg::round_shift(66'(mx_r), 30) + 66'(ctr_r.x));
  assign cy = tosp_pkg::clip32(tosp_pkg::round_shift(66'(my_r), 30) + 66'(ctr_r.y));
  assign cz = tosp_pkg::clip32(tosp_pkg::round_shift(66'(mz_r), 30) + 66'(ctr_r.z));

  always_comb begin
    pt_nxt.p.x = cx.val;
    pt_nxt.p.y = cy.val;
    pt_nxt.p.z = cz.val;
    pt_nxt.sat = sat_r | cx.sat | cy.sat | cz.sat;
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      pt_r <= pt_nxt;
    end
  end

  assign point = pt_r;

endmodule
